FILE: rtl/cle_pkg.sv
// Shared types and codes for the circular list engine.
package cle_pkg;

	typedef enum logic [2:0] {
		CMD_INS_FRONT = 3'd0,
		CMD_INS_END   = 3'd1,
		CMD_INS_POS   = 3'd2,
		CMD_DEL_FRONT = 3'd3,
		CMD_DEL_END   = 3'd4,
		CMD_DEL_POS   = 3'd5,
		CMD_DEL_VALUE = 3'd6,
		CMD_READ_OUT  = 3'd7
	} cmd_t;

	localparam logic [1:0] ST_DONE     = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_WALK,
		S_LINK_RD,
		S_LINK_WR,
		S_UNLINK_RD,
		S_UNLINK_WR,
		S_READ,
		S_EMIT
	} state_t;

endpackage

FILE: rtl/cle_in_if.sv
// Command channel interface.
interface cle_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         cmd;
	logic signed [31:0] value;
	logic [7:0]         position;
	modport source (output valid, cmd, value, position, input ready);
	modport sink (input valid, cmd, value, position, output ready);
endinterface

FILE: rtl/cle_out_if.sv
// Result channel interface.
interface cle_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] element;
	logic [4:0]         count;
	logic               last;
	modport source (output valid, status, element, count, last, input ready);
	modport sink (input valid, status, element, count, last, output ready);
endinterface

FILE: rtl/circular_list_engine_unit.sv
// Circular doubly linked list engine kept in synchronous memories.
// Usage:
//   Commands arrive on the in channel (cmd, value, position); results
//   leave on the out channel (status, element, count, last). Each command
//   gives one result, except read-out, which gives one result per element
//   (one result with status empty for an empty list), last set on the final.
//   One command is worked on at a time. The links live in memories with a
//   registered read; every walk step costs one memory read, so a command
//   takes longer for each link walked before its result shows: positional
//   and value deletes and inserts after a position walk at most
//   CAPACITY - 1 links, and read-out reads each element and its links
//   from memory before giving its result.
//   A result is held in an output register until taken; while the
//   receiver stalls the engine waits, and a new command is taken once the
//   final result of the previous one has been accepted.
//   Reset clears the used-slot mask, the head and the count; the memories
//   need no clearing, since only used slots are ever read.
module circular_list_engine_unit #(
	parameter int CAPACITY = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	cle_in_if.sink     in_ch,
	cle_out_if.source  out_ch
);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	logic [31:0]   elem_mem [CAPACITY];
	logic [AW-1:0] next_mem [CAPACITY];
	logic [AW-1:0] prev_mem [CAPACITY];

	cle_pkg::state_t state_q, state_d;
	logic [CAPACITY-1:0] used_q, used_d;
	logic [AW-1:0] head_q, head_d;
	logic [CW-1:0] cnt_q, cnt_d;

	logic [2:0]  cmd_q;
	logic [31:0] val_q;
	logic [7:0]  pos_q;
	logic [CW-1:0] steps_q, steps_d;
	logic [AW-1:0] cur_q, cur_d;
	logic [AW-1:0] nx_q, nx_d, pv_q, pv_d;
	logic [AW-1:0] free_slot;

	// memory port controls
	logic [AW-1:0] rd_addr;
	logic [31:0]   rd_elem;
	logic [AW-1:0] rd_next, rd_prev;
	logic          we_elem;
	logic [AW-1:0] wa_elem;
	logic          we_n1, we_n2, we_p1, we_p2;
	logic [AW-1:0] wa_n1, wd_n1, wa_n2, wd_n2, wa_p1, wd_p1, wa_p2, wd_p2;

	logic          ov_q, ov_d, olast_q, olast_d;
	logic [1:0]    ost_q, ost_d;
	logic [31:0]   oel_q, oel_d;
	logic [CW-1:0] ocnt_q, ocnt_d;

	always_comb begin
		free_slot = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_slot = AW'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_elem <= elem_mem[rd_addr];
		rd_next <= next_mem[rd_addr];
		rd_prev <= prev_mem[rd_addr];
		if (we_elem) elem_mem[wa_elem] <= val_q;
		if (we_n1) next_mem[wa_n1] <= wd_n1;
		if (we_n2) next_mem[wa_n2] <= wd_n2;
		if (we_p1) prev_mem[wa_p1] <= wd_p1;
		if (we_p2) prev_mem[wa_p2] <= wd_p2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cle_pkg::S_IDLE;
			used_q  <= '0;
			head_q  <= '0;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			used_q  <= used_d;
			head_q  <= head_d;
			cnt_q   <= cnt_d;
			ov_q    <= ov_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			cmd_q <= in_ch.cmd;
			val_q <= in_ch.value;
			pos_q <= in_ch.position;
		end
		steps_q <= steps_d;
		cur_q   <= cur_d;
		nx_q    <= nx_d;
		pv_q    <= pv_d;
		olast_q <= olast_d;
		ost_q   <= ost_d;
		oel_q   <= oel_d;
		ocnt_q  <= ocnt_d;
	end

	assign in_ch.ready   = (state_q == cle_pkg::S_IDLE) && !ov_q;
	assign out_ch.valid  = ov_q;
	assign out_ch.status = ost_q;
	assign out_ch.element = oel_q;
	assign out_ch.count  = 5'(ocnt_q);
	assign out_ch.last   = olast_q;

	always_comb begin
		logic is_ins, front_ins;
		logic [8:0] pos_w, cnt_w;
		is_ins    = (cmd_q == cle_pkg::CMD_INS_FRONT) || (cmd_q == cle_pkg::CMD_INS_END)
		         || (cmd_q == cle_pkg::CMD_INS_POS);
		front_ins = (cmd_q == cle_pkg::CMD_INS_FRONT)
		         || ((cmd_q == cle_pkg::CMD_INS_POS) && (pos_q == 8'd0));
		pos_w     = {1'b0, pos_q};
		cnt_w     = 9'(cnt_q);
		state_d = state_q;
		used_d  = used_q;
		head_d  = head_q;
		cnt_d   = cnt_q;
		steps_d = steps_q;
		cur_d   = cur_q;
		nx_d    = nx_q;
		pv_d    = pv_q;
		ov_d    = ov_q;
		olast_d = olast_q;
		ost_d   = ost_q;
		oel_d   = oel_q;
		ocnt_d  = ocnt_q;
		rd_addr = cur_q;
		we_elem = 1'b0; wa_elem = free_slot;
		we_n1 = 1'b0; wa_n1 = '0; wd_n1 = '0;
		we_n2 = 1'b0; wa_n2 = '0; wd_n2 = '0;
		we_p1 = 1'b0; wa_p1 = '0; wd_p1 = '0;
		we_p2 = 1'b0; wa_p2 = '0; wd_p2 = '0;
		if (ov_q && out_ch.ready) ov_d = 1'b0;

		unique case (state_q)
			cle_pkg::S_IDLE: begin
				if (in_ch.valid && in_ch.ready) begin
					state_d = cle_pkg::S_DECIDE;
				end
			end
			cle_pkg::S_DECIDE: begin
				// read head so that its prev link is at hand next cycle
				cur_d   = head_q;
				rd_addr = head_q;
				steps_d = '0;
				state_d = cle_pkg::S_IDLE;
				ost_d = cle_pkg::ST_DONE; oel_d = '0; olast_d = 1'b1;
				ocnt_d = cnt_q;
				if (cmd_q == cle_pkg::CMD_READ_OUT) begin
					if (cnt_q == '0) begin
						ost_d = cle_pkg::ST_EMPTY; ov_d = 1'b1;
					end else begin
						state_d = cle_pkg::S_READ;
					end
				end else if (is_ins) begin
					if (cnt_q >= CW'(CAPACITY)) begin
						ost_d = cle_pkg::ST_FULL; ov_d = 1'b1;
					end else if (cnt_q == '0) begin
						we_elem = 1'b1;
						we_n1 = 1'b1; wa_n1 = free_slot; wd_n1 = free_slot;
						we_p1 = 1'b1; wa_p1 = free_slot; wd_p1 = free_slot;
						used_d[free_slot] = 1'b1;
						head_d = free_slot;
						cnt_d  = CW'(1);
						ocnt_d = CW'(1);
						ov_d = 1'b1;
					end else if (cmd_q == cle_pkg::CMD_INS_POS && !front_ins
					             && pos_w > cnt_w) begin
						ost_d = cle_pkg::ST_NOTFOUND; ov_d = 1'b1;
					end else begin
						// walk target: pos-1 links for after-pos, tail otherwise
						steps_d = (cmd_q == cle_pkg::CMD_INS_POS && !front_ins)
						          ? CW'(pos_w - 9'd1) : '0;
						state_d = cle_pkg::S_WALK;
					end
				end else if (cnt_q == '0) begin
					ost_d = cle_pkg::ST_EMPTY; ov_d = 1'b1;
				end else if (cmd_q == cle_pkg::CMD_DEL_POS
				             && (pos_q == 8'd0 || pos_w > cnt_w)) begin
					ost_d = cle_pkg::ST_NOTFOUND; ov_d = 1'b1;
				end else begin
					steps_d = (cmd_q == cle_pkg::CMD_DEL_POS) ? CW'(pos_w - 9'd1) : '0;
					state_d = cle_pkg::S_WALK;
				end
			end
			cle_pkg::S_WALK: begin
				// rd_* holds the links of cur_q
				priority if (cmd_q == cle_pkg::CMD_INS_FRONT || cmd_q == cle_pkg::CMD_INS_END
				             || (cmd_q == cle_pkg::CMD_INS_POS && pos_q == 8'd0)) begin
					cur_d = rd_prev; rd_addr = rd_prev;
					state_d = cle_pkg::S_LINK_RD;
				end else if (cmd_q == cle_pkg::CMD_DEL_END) begin
					cur_d = rd_prev; rd_addr = rd_prev;
					state_d = cle_pkg::S_UNLINK_RD;
				end else if (cmd_q == cle_pkg::CMD_DEL_VALUE) begin
					if (rd_elem == val_q) begin
						state_d = cle_pkg::S_UNLINK_RD;
					end else if (steps_q + CW'(1) >= cnt_q) begin
						ost_d = cle_pkg::ST_NOTFOUND; olast_d = 1'b1; oel_d = '0;
						ocnt_d = cnt_q; ov_d = 1'b1;
						state_d = cle_pkg::S_IDLE;
					end else begin
						steps_d = steps_q + CW'(1);
						cur_d = rd_next; rd_addr = rd_next;
					end
				end else if (steps_q == '0) begin
					state_d = (cmd_q == cle_pkg::CMD_INS_POS) ? cle_pkg::S_LINK_RD
					                                          : cle_pkg::S_UNLINK_RD;
				end else begin
					steps_d = steps_q - CW'(1);
					cur_d = rd_next; rd_addr = rd_next;
				end
			end
			cle_pkg::S_LINK_RD: begin
				// rd_next is the successor of cur_q
				nx_d = rd_next;
				state_d = cle_pkg::S_LINK_WR;
			end
			cle_pkg::S_LINK_WR: begin
				we_elem = 1'b1;
				we_n1 = 1'b1; wa_n1 = free_slot; wd_n1 = nx_q;
				we_p1 = 1'b1; wa_p1 = free_slot; wd_p1 = cur_q;
				we_p2 = 1'b1; wa_p2 = nx_q;      wd_p2 = free_slot;
				we_n2 = 1'b1; wa_n2 = cur_q;     wd_n2 = free_slot;
				used_d[free_slot] = 1'b1;
				if (front_ins) head_d = free_slot;
				cnt_d = cnt_q + CW'(1);
				ost_d = cle_pkg::ST_DONE; oel_d = '0; olast_d = 1'b1;
				ocnt_d = cnt_q + CW'(1); ov_d = 1'b1;
				state_d = cle_pkg::S_IDLE;
			end
			cle_pkg::S_UNLINK_RD: begin
				nx_d = rd_next;
				pv_d = rd_prev;
				state_d = cle_pkg::S_UNLINK_WR;
			end
			cle_pkg::S_UNLINK_WR: begin
				if (cnt_q <= CW'(1)) begin
					head_d = '0;
					cnt_d  = '0;
				end else begin
					we_n1 = 1'b1; wa_n1 = pv_q; wd_n1 = nx_q;
					we_p1 = 1'b1; wa_p1 = nx_q; wd_p1 = pv_q;
					if (cur_q == head_q) head_d = nx_q;
					cnt_d = cnt_q - CW'(1);
				end
				used_d[cur_q] = 1'b0;
				ost_d = cle_pkg::ST_DONE; oel_d = '0; olast_d = 1'b1;
				ocnt_d = (cnt_q <= CW'(1)) ? '0 : cnt_q - CW'(1);
				ov_d = 1'b1;
				state_d = cle_pkg::S_IDLE;
			end
			cle_pkg::S_READ: begin
				// rd_* holds cur_q; present it when the output register is free or being taken
				if (!ov_q || out_ch.ready) begin
					ost_d = cle_pkg::ST_DONE; oel_d = rd_elem; ocnt_d = cnt_q;
					olast_d = (steps_q + CW'(1) == cnt_q);
					ov_d = 1'b1;
					cur_d = rd_next;
					steps_d = steps_q + CW'(1);
					state_d = (steps_q + CW'(1) == cnt_q) ? cle_pkg::S_IDLE
					                                      : cle_pkg::S_EMIT;
				end else begin
					rd_addr = cur_q;
				end
			end
			cle_pkg::S_EMIT: begin
				rd_addr = cur_q;
				state_d = cle_pkg::S_READ;
			end
			default: state_d = cle_pkg::S_IDLE;
		endcase
	end
endmodule

FILE: rtl/cle_checker.sv
// Port-level checks for the circular list engine, bound to the top level.
module cle_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] status,
	input logic [4:0] count,
	input logic       last,
	input logic [31:0] element
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(element) && $stable(last))
		else $error("result changed while stalled");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("command taken while a result waits");
	a_zero_elem: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != 2'd0 |-> element == 32'd0 && last)
		else $error("non-done result not final or element set");
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == 2'd1 |-> count == 5'd0)
		else $error("empty status with nonzero count");
endmodule

bind circular_list_engine_unit cle_checker u_cle_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.status(out_ch.status), .count(out_ch.count),
	.last(out_ch.last), .element(out_ch.element)
);
